// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ipv6p_pkg.sv =====
// Shared types, character codes and helpers for the IPv6 text address parser.
// Depends on nothing; used by every module in rtl/core.
`default_nettype none

package ipv6p_pkg;

	localparam int unsigned NumGroups = 8;

	localparam logic [3:0] NO_DC       = 4'd8;
	localparam logic [3:0] GROUPS_FULL = 4'd8;
	localparam logic [2:0] MAX_DIGITS  = 3'd4;
	localparam logic [1:0] DOUBLE_RUN  = 2'd2;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_MANY  = 3'd1,
		ST_TOO_LONG  = 3'd2,
		ST_SECOND_DC = 3'd3,
		ST_TOO_FEW   = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_char;
	} char_beat_t;

	typedef struct packed {
		logic [63:0] address_upper;
		logic [63:0] address_lower;
		logic [2:0]  parse_status;
		logic [7:0]  chars_consumed;
	} addr_beat_t;

	typedef logic [NumGroups-1:0][15:0] group_row_t;

	typedef struct packed {
		logic [15:0] group_value;
		logic [2:0]  digit_count;
		logic [3:0]  group_count;
		logic [1:0]  colon_run;
		logic [3:0]  dc_pos;
		logic        stopped;
		status_t     error;
		logic [7:0]  consumed;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		group_value: 16'h0000,
		digit_count: 3'd0,
		group_count: 4'd0,
		colon_run:   2'd0,
		dc_pos:      NO_DC,
		stopped:     1'b0,
		error:       ST_OK,
		consumed:    8'd0
	};

	// {is_hex, nibble}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		logic [4:0] r;
		d = 8'd0;
		r = 5'd0;
		if (c >= CH_0 && c <= CH_9) begin
			d = c - CH_0;
			r = {1'b1, d[3:0]};
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = c - CH_LA + HEX_TEN;
			r = {1'b1, d[3:0]};
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = c - CH_UA + HEX_TEN;
			r = {1'b1, d[3:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ipv6p_scan.sv =====
// Character scanner: group gathering state, colon tracking and the group row.
// Depends on ipv6p_pkg.
`default_nettype none

module ipv6p_scan (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  ipv6p_pkg::char_beat_t   beat,
	output ipv6p_pkg::scan_state_t  state_nx,
	output ipv6p_pkg::group_row_t   row_nx
);
	import ipv6p_pkg::*;

	scan_state_t state_q;
	logic [NumGroups-1:0][15:0] row_q;
	logic [4:0] hex;
	logic       is_colon;
	logic [1:0] run_inc;
	logic       wr_en;
	logic [2:0] wr_idx;

	assign wr_idx = state_q.group_count[2:0];

	always_comb begin
		hex      = hex_value(beat.char_byte);
		is_colon = (beat.char_byte == CH_COLON) && (state_q.colon_run < DOUBLE_RUN);
		run_inc  = state_q.colon_run + 2'd1;
		state_nx = state_q;
		wr_en    = 1'b0;
		if (!state_q.stopped) begin
			if (!hex[4] && !is_colon) begin
				state_nx.stopped = 1'b1;
			end else begin
				if (state_q.consumed != 8'hFF) begin
					state_nx.consumed = state_q.consumed + 8'd1;
				end
				if (state_q.group_count >= GROUPS_FULL) begin
					state_nx.error   = ST_TOO_MANY;
					state_nx.stopped = 1'b1;
				end else if (hex[4]) begin
					if (state_q.digit_count >= MAX_DIGITS) begin
						state_nx.error   = ST_TOO_LONG;
						state_nx.stopped = 1'b1;
					end else begin
						state_nx.group_value = {state_q.group_value[11:0], hex[3:0]};
						state_nx.colon_run   = 2'd0;
						state_nx.digit_count = state_q.digit_count + 3'd1;
					end
				end else begin
					state_nx.colon_run = run_inc;
					if (run_inc == DOUBLE_RUN && state_q.dc_pos != NO_DC) begin
						state_nx.error   = ST_SECOND_DC;
						state_nx.stopped = 1'b1;
					end else begin
						if (run_inc == DOUBLE_RUN) begin
							state_nx.dc_pos = state_q.group_count;
						end
						// close the open group
						if (state_q.digit_count != 3'd0) begin
							wr_en                = 1'b1;
							state_nx.group_count = state_q.group_count + 4'd1;
							state_nx.group_value = 16'h0000;
							state_nx.digit_count = 3'd0;
						end
					end
				end
			end
		end
	end

	always_comb begin
		row_nx = row_q;
		if (wr_en) begin
			row_nx[wr_idx] = state_q.group_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_RESET;
		end else if (step) begin
			state_q <= beat.last_char ? SCAN_RESET : state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			row_q[wr_idx] <= state_q.group_value;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ipv6p_expand.sv =====
// Finalization: closes the open group, expands "::" and forms status and address.
// Depends on ipv6p_pkg.
`default_nettype none

module ipv6p_expand (
	input  ipv6p_pkg::scan_state_t state,
	input  ipv6p_pkg::group_row_t  row,
	output ipv6p_pkg::addr_beat_t  result
);
	import ipv6p_pkg::*;

	group_row_t eff;
	group_row_t shifted;
	group_row_t g;
	logic [3:0] n;
	logic [3:0] zeros;
	logic [4:0] gap_end;
	logic [7:0] shamt;
	logic       has_dc;
	status_t    status;

	always_comb begin
		eff = row;
		n   = state.group_count;
		if (state.digit_count != 3'd0 && state.group_count < GROUPS_FULL) begin
			eff[state.group_count[2:0]] = state.group_value;
			n = state.group_count + 4'd1;
		end
		has_dc  = (state.dc_pos != NO_DC);
		zeros   = GROUPS_FULL - n;
		gap_end = {1'b0, state.dc_pos} + {1'b0, zeros};
		shamt   = {zeros, 4'b0000};
		// move the groups after "::" up by the number of zero groups
		shifted = group_row_t'(eff << shamt);
		g       = eff;
		if (has_dc) begin
			for (int i = 0; i < NumGroups; i++) begin
				if (5'(i) < {1'b0, state.dc_pos}) begin
					g[i] = eff[i];
				end else if (5'(i) < gap_end) begin
					g[i] = 16'h0000;
				end else begin
					g[i] = shifted[i];
				end
			end
		end
		status = state.error;
		if (state.error == ST_OK && !has_dc && n != GROUPS_FULL) begin
			status = ST_TOO_FEW;
		end
		result.parse_status   = status;
		result.chars_consumed = state.consumed;
		if (status == ST_OK) begin
			result.address_upper = {g[0], g[1], g[2], g[3]};
			result.address_lower = {g[4], g[5], g[6], g[7]};
		end else begin
			result.address_upper = 64'h0;
			result.address_lower = 64'h0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ipv6_text_address_parser_core.sv =====
// Top level of the IPv6 text address parser: input stage, scanner, finalizer, result stage.
// Depends on ipv6p_pkg, ipv6p_scan, ipv6p_expand and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// The parser takes the text of an IPv6 address one character per beat on the
// char channel and returns one beat on the addr channel for each character
// marked last_char. Hex digits in either case and up to two colons in a row are
// taken; the first other character stops the scan and the rest of the address,
// up to and including the last character, is ignored. The result carries the
// 128-bit address (group 0 in the top bits of address_upper), a status (ok, too
// many groups, group longer than four digits, second "::", too few groups) and
// the count of consumed characters, saturating at 255. On any error the address
// reads as zero. Throughput is one character per clock while no last character
// waits for the result register: the scanner updates its state on each step
// and the "::" expansion is a mux shift over the eight stored groups. A last
// character that is accepted sits in the input stage, and its result is loaded
// into the result register once that register is free. A result waiting under
// stall does not block further characters; only a second last character is
// held in the input stage until the result register frees up. Payload beats
// are packed structs from ipv6p_pkg.
module ipv6_text_address_parser_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  ipv6p_pkg::char_beat_t char_beat,
	output logic                  addr_valid,
	input  logic                  addr_stall,
	output ipv6p_pkg::addr_beat_t addr_beat
);
	import ipv6p_pkg::*;

	logic        valid_s1;
	char_beat_t  beat_s1;
	logic        addr_valid_q;
	addr_beat_t  addr_beat_q;
	logic        out_free;
	logic        step;
	logic        take;
	scan_state_t state_nx;
	group_row_t  row_nx;
	addr_beat_t  result;

	// The result register can take a new beat when empty or being drained.
	assign out_free = !addr_valid_q || !addr_stall;

	// Work the staged character; a last character needs room for its result.
	assign step = valid_s1 && (!beat_s1.last_char || out_free);

	// Stall only when the input stage is full and cannot advance.
	assign char_stall = valid_s1 && !step;
	assign take       = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beat_s1 <= char_beat;
		end
	end

	ipv6p_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.beat     (beat_s1),
		.state_nx (state_nx),
		.row_nx   (row_nx)
	);

	ipv6p_expand u_expand (
		.state  (state_nx),
		.row    (row_nx),
		.result (result)
	);

	// Load the result on a finished address; drop the valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_valid_q <= 1'b0;
		end else if (step && beat_s1.last_char) begin
			addr_valid_q <= 1'b1;
		end else if (!addr_stall) begin
			addr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && beat_s1.last_char) begin
			addr_beat_q <= result;
		end
	end

	assign addr_valid = addr_valid_q;
	assign addr_beat  = addr_beat_q;

	`AST_IMPLIES(a_err_zero_addr, clk, arst_n,
		addr_valid && addr_beat.parse_status != ST_OK,
		addr_beat.address_upper == 64'h0 && addr_beat.address_lower == 64'h0,
		"address not zero on error status")
	`AST_IMPLIES(a_status_range, clk, arst_n,
		addr_valid,
		addr_beat.parse_status <= ST_TOO_FEW,
		"status code out of range")
	`AST_NEXT(a_last_gives_result, clk, arst_n,
		step && beat_s1.last_char,
		addr_valid,
		"finished address produced no result beat")

endmodule

`default_nettype wire

// ===== test/ipv6_text_address_parser_core_tb.sv =====
// Testbench for ipv6_text_address_parser_core: streams address text, one character per beat.
// Depends on ipv6p_pkg for the beat structs, status codes and character constants.
`timescale 1ns / 1ps

module ipv6_text_address_parser_core_tb;
	import ipv6p_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_REPORTS  = 10;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_stall;
	char_beat_t char_beat  = '0;
	logic       addr_valid;
	logic       addr_stall = 1'b0;
	addr_beat_t addr_beat;

	ipv6_text_address_parser_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.addr_valid (addr_valid),
		.addr_stall (addr_stall),
		.addr_beat  (addr_beat)
	);

	always #CLK_HALF clk = ~clk;

	// Idle and stall odds, in percent of cycles; set per phase.
	int send_idle_pct  = 0;
	int addr_stall_pct = 0;

	int cycle_count   = 0;
	int mismatches    = 0;
	int scanned_chars = 0;

	// Addresses predicted but not yet seen on the addr channel, oldest first.
	addr_beat_t addr_due[$];

	// Scratch text of the next random address.
	logic [7:0] text_q[$];

	// Scanner image: groups gathered so far and the scan bookkeeping.
	logic [15:0] grp_store [NumGroups];
	logic [15:0] grp_val;
	logic [2:0]  n_digits;
	logic [3:0]  n_groups;
	logic [1:0]  colons;
	logic [3:0]  dc_at;
	logic        halted;
	status_t     err;
	logic [7:0]  n_used;

	function automatic void clear_scan();
		grp_val  = '0;
		n_digits = '0;
		n_groups = '0;
		colons   = '0;
		dc_at    = NO_DC;
		halted   = 1'b0;
		err      = ST_OK;
		n_used   = '0;
	endfunction

	// Advance the scanner image by one character. Returns 0 when the scan had
	// already stopped, so the character is simply dropped by the block.
	function automatic bit take_char(input logic [7:0] c);
		logic [3:0] nib;
		bit         is_colon;
		if (halted)
			return 1'b0;
		nib      = '0;
		is_colon = 1'b0;
		if (c >= CH_0 && c <= CH_9) begin
			nib = 4'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LF) begin
			nib = 4'(c - CH_LA + HEX_TEN);
		end else if (c >= CH_UA && c <= CH_UF) begin
			nib = 4'(c - CH_UA + HEX_TEN);
		end else if (c == CH_COLON && colons < DOUBLE_RUN) begin
			is_colon = 1'b1;
		end else begin
			// Third colon in a row or a foreign character: stop, not consumed.
			halted = 1'b1;
			return 1'b1;
		end

		if (n_used != 8'hFF)
			n_used++;

		if (n_groups >= GROUPS_FULL) begin
			err    = ST_TOO_MANY;
			halted = 1'b1;
			return 1'b1;
		end

		if (!is_colon) begin
			if (n_digits >= MAX_DIGITS) begin
				err    = ST_TOO_LONG;
				halted = 1'b1;
				return 1'b1;
			end
			grp_val = {grp_val[11:0], nib};
			colons  = '0;
			n_digits++;
			return 1'b1;
		end

		colons++;
		if (colons == DOUBLE_RUN) begin
			if (dc_at < NO_DC) begin
				err    = ST_SECOND_DC;
				halted = 1'b1;
				return 1'b1;
			end
			dc_at = n_groups;
		end
		if (n_digits != 0) begin
			grp_store[n_groups[2:0]] = grp_val;
			n_groups++;
			grp_val  = '0;
			n_digits = '0;
		end
		return 1'b1;
	endfunction

	// Close the address: commit the open group, expand "::" into zero groups
	// and queue the expected beat, then start over for the next address.
	function automatic void finish_address();
		logic [15:0] grp [NumGroups];
		addr_beat_t  want;
		int          n;
		int          zeros;
		status_t     status;
		status = err;
		want   = '0;
		if (status == ST_OK) begin
			n = int'(n_groups);
			if (n_digits != 0 && n < NumGroups) begin
				grp_store[n] = grp_val;
				n++;
			end
			if (dc_at < NO_DC && int'(dc_at) <= n) begin
				zeros = NumGroups - n;
				for (int i = 0; i < NumGroups; i++) begin
					if (i < int'(dc_at))
						grp[i] = grp_store[i];
					else if (i < int'(dc_at) + zeros)
						grp[i] = '0;
					else
						grp[i] = grp_store[(i - zeros) & 7];
				end
				n = NumGroups;
			end else begin
				for (int i = 0; i < NumGroups; i++)
					grp[i] = (i < n) ? grp_store[i] : 16'h0000;
			end
			if (n < NumGroups) begin
				status = ST_TOO_FEW;
			end else begin
				want.address_upper = {grp[0], grp[1], grp[2], grp[3]};
				want.address_lower = {grp[4], grp[5], grp[6], grp[7]};
			end
		end
		want.parse_status   = status;
		want.chars_consumed = n_used;
		addr_due.push_back(want);
		clear_scan();
	endfunction

	// Offer one character beat, idling first at the phase's odds. Valid stays
	// high after acceptance so back-to-back beats never toggle it within a step.
	task automatic send_char(input logic [7:0] c, input logic last);
		bit active;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_beat  <= '{char_byte: c, last_char: last};
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		active = take_char(c);
		if (active)
			scanned_chars++;
		if (last)
			finish_address();
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] rand_hex_char();
		int k;
		k = $urandom_range(0, 21);
		if (k < 10)
			return 8'(CH_0 + k);
		else if (k < 16)
			return 8'(CH_LA + k - 10);
		return 8'(CH_UA + k - 16);
	endfunction

	// Fill text_q with one address: mostly well-formed groups around an
	// optional "::", with some noise, broken runs and trailing junk.
	task automatic build_random_text();
		int   shape;
		int   n_grp;
		int   dc_pos;
		int   n_dig;
		int   fill;
		int   k;
		logic use_dc;
		text_q.delete();
		shape = $urandom_range(0, 99);
		if (shape < 8) begin
			repeat ($urandom_range(1, 10))
				text_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		use_dc = 1'($urandom_range(0, 1));
		if (use_dc)
			n_grp = $urandom_range(0, 8);
		else if (shape < 60)
			n_grp = 8;
		else
			n_grp = $urandom_range(1, 9);
		if (shape >= 94)
			n_grp = 9;
		dc_pos = $urandom_range(0, n_grp);

		for (int g = 0; g <= n_grp; g++) begin
			if (use_dc && g == dc_pos) begin
				text_q.push_back(CH_COLON);
				text_q.push_back(CH_COLON);
			end else if (g > 0 && g < n_grp) begin
				text_q.push_back(CH_COLON);
			end
			if (g < n_grp) begin
				n_dig = ($urandom_range(0, 99) < 4) ? 5 : $urandom_range(1, 4);
				fill  = $urandom_range(0, 9);
				for (int d = 0; d < n_dig; d++) begin
					if (fill == 0)
						text_q.push_back(d[0] ? CH_UF : CH_LF);
					else if (fill == 1)
						text_q.push_back(CH_0);
					else
						text_q.push_back(rand_hex_char());
				end
			end
		end

		k = $urandom_range(0, 99);
		if (k < 6 && use_dc) begin
			text_q.push_back(CH_COLON);
			text_q.push_back(CH_COLON);
			text_q.push_back(rand_hex_char());
		end else if (k < 12 && text_q.size() > 0) begin
			text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (k < 16) begin
			text_q.insert($urandom_range(0, text_q.size()), CH_COLON);
		end
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 5))
				text_q.push_back(8'($urandom_range(0, 255)));
		if (text_q.size() == 0)
			text_q.push_back(rand_hex_char());
	endtask

	// Short addresses aimed at each way the scan can end, all but too many groups.
	task automatic test_special_cases();
		send_text("::");      // all-zero address
		send_text(":::");     // third colon stops the scan
		send_text("12345");   // group longer than four digits
		send_text("::a::");   // second double colon
		send_text("B");       // too few groups
		send_text("9:");      // too few, group committed by a colon
		send_text("0::F");    // expansion in the middle
		send_char(8'h00, 1'b0); // foreign byte stops at once
		send_char(8'hFF, 1'b1); // dropped, only closes the address
	endtask

	// Stream random addresses until the phase has scanned its share of beats.
	task automatic test_random_addresses(input int idle_pct, input int stall_pct,
	                                     input int n_chars);
		int stop_at;
		send_idle_pct  = idle_pct;
		addr_stall_pct = stall_pct;
		stop_at        = scanned_chars + n_chars;
		while (scanned_chars < stop_at) begin
			build_random_text();
			foreach (text_q[i])
				send_char(text_q[i], i == text_q.size() - 1);
		end
	endtask

	// Check each accepted address beat against the oldest prediction, then
	// pick the stall for the next cycle.
	always @(posedge clk) begin : addr_check
		addr_beat_t want;
		if (arst_n && addr_valid && !addr_stall) begin
			if (addr_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected address beat: %h", addr_beat);
			end else begin
				want = addr_due.pop_front();
				if (addr_beat.address_upper !== want.address_upper ||
				    addr_beat.address_lower !== want.address_lower ||
				    addr_beat.parse_status !== want.parse_status ||
				    addr_beat.chars_consumed !== want.chars_consumed) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("address mismatch: expected %h_%h st %0d n %0d, got %h_%h st %0d n %0d",
						         want.address_upper, want.address_lower,
						         want.parse_status, want.chars_consumed,
						         addr_beat.address_upper, addr_beat.address_lower,
						         addr_beat.parse_status, addr_beat.chars_consumed);
				end
			end
		end
		addr_stall <= ($urandom_range(0, 99) < addr_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		clear_scan();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_random_addresses(0, 0, 260);
		test_random_addresses(81, 0, 260);
		test_random_addresses(0, 81, 260);
		test_random_addresses(27, 27, 260);

		char_valid <= 1'b0;
		// Anything still predicted here ends in the cycle limit.
		while (addr_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ipv6p_pkg.sv
rtl/core/ipv6p_scan.sv
rtl/core/ipv6p_expand.sv
rtl/core/ipv6_text_address_parser_core.sv
test/ipv6_text_address_parser_core_tb.sv
